// ===== sv/double_hash_table_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double hashing table engine
// Shared checker macros, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define DHTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dhte_pkg.sv =====
// ----------------------------------------------------------------------------
// dhte_pkg
// Widths, codes and controller/datapath bundles of the hash table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

  localparam int CAPACITY   = 128;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 31;
  localparam int AGE_W      = 8;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int SIZE_W     = 8;
  localparam int PRIME_W    = 7;
  localparam int MEAN_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SUM_W      = AGE_W + IDX_W + 1;
  localparam int DIV_W      = KEY_W;
  localparam int DIVS_W     = SIZE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PRIME = 1'd1;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_AVERAGE = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef enum logic [1:0] {DIV_HOME, DIV_PRIME, DIV_STEP, DIV_MEAN} div_sel_t;

  typedef enum logic [2:0] {RES_HIT, RES_MISS, RES_BAD, RES_NONE, RES_MEAN} res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      item_ld;
    logic      div_start;
    div_sel_t  div_sel;
    logic      home_ld;
    logic      step_p_ld;
    logic      step_n_ld;
    logic      probe_adv;
    logic      slot_wr;
    logic      scan_sel;
    logic      avg_clr;
    logic      avg_adv;
    logic      out_ld;
    res_kind_t res_kind;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             div_done;
    logic             walk_end;
    logic             slot_hit;
    logic             slot_empty;
    logic             scan_end;
    logic             count_zero;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== sv/dhte_ifs.sv =====
// ----------------------------------------------------------------------------
// dhte channel interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface dhte_in_if import dhte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] record_key;
  logic [AGE_W-1:0] record_age;
  modport source (output valid, cmd, record_key, record_age, input ready);
  modport sink   (input valid, cmd, record_key, record_age, output ready);
endinterface

interface dhte_out_if import dhte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot_index;
  logic [CNT_W-1:0]    probe_count;
  logic [MEAN_W-1:0]   mean_age;
  modport source (output valid, status, slot_index, probe_count, mean_age, input ready);
  modport sink   (input valid, status, slot_index, probe_count, mean_age, output ready);
endinterface

interface dhte_cfg_if import dhte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== sv/dhte_ram.sv =====
// ----------------------------------------------------------------------------
// dhte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dhte_div.sv =====
// ----------------------------------------------------------------------------
// dhte_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhte_div import dhte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient,
  output logic [DIVS_W-1:0] remainder
);

  localparam int ITER_W = $clog2(DIV_W);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;
  logic [DIVS_W-1:0] rem_nxt;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIV_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fits ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(DIV_W - 1);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/dhte_datapath.sv =====
// ----------------------------------------------------------------------------
// dhte_datapath
// Config registers, slot store, probe arithmetic, averaging and result register.
// ----------------------------------------------------------------------------
module dhte_datapath import dhte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             ctrl,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [AGE_W-1:0]      in_age,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IDX_W-1:0]      out_slot,
  output logic [CNT_W-1:0]      out_probes,
  output logic [MEAN_W-1:0]     out_mean
);

  logic [SIZE_W-1:0]   size_r;
  logic [PRIME_W-1:0]  prime_r;
  logic [SIZE_W-1:0]   n_eff;
  logic [PRIME_W-1:0]  p_eff;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [AGE_W-1:0]    age_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_nxt;
  logic [PRIME_W-1:0]  step_r;
  logic [CNT_W-1:0]    probes_r;
  logic [CNT_W-1:0]    scan_r;
  logic [SUM_W-1:0]    total_r;
  logic [CNT_W-1:0]    count_r;
  logic [SIZE_W-1:0]   idx_sum;
  logic [DIV_W-1:0]    div_dvd;
  logic [DIVS_W-1:0]   div_dvs;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;
  logic [DIVS_W-1:0]   div_rem;
  logic [CAPACITY-1:0] vld_r;
  logic                vld_q_r;
  logic [IDX_W-1:0]    ram_addr;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic [1:0]          rd_mark;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [CNT_W-1:0]    out_probes_r;
  logic [MEAN_W-1:0]   out_mean_r;

  // config registers, always ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_W'(CAPACITY);
      prime_r <= PRIME_W'(CAPACITY - 1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TABLE_SIZE: size_r  <= cfg_data[SIZE_W-1:0];
        REG_STEP_PRIME: prime_r <= cfg_data[PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp config into legal range
  always_comb begin
    if (size_r < SIZE_W'(2))             n_eff = SIZE_W'(2);
    else if (size_r > SIZE_W'(CAPACITY)) n_eff = SIZE_W'(CAPACITY);
    else                                 n_eff = size_r;
    p_eff = (prime_r < PRIME_W'(2)) ? PRIME_W'(3) : prime_r;
  end

  // divider operand select
  always_comb begin
    case (ctrl.div_sel)
      DIV_HOME:  begin div_dvd = key_r;               div_dvs = n_eff;              end
      DIV_PRIME: begin div_dvd = key_r;               div_dvs = DIVS_W'(p_eff);     end
      DIV_STEP:  begin div_dvd = DIV_W'(step_r);      div_dvs = n_eff;              end
      DIV_MEAN:  begin div_dvd = DIV_W'(total_r);     div_dvs = count_r;            end
      default:   begin div_dvd = key_r;               div_dvs = n_eff;              end
    endcase
  end

  dhte_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next probe slot: step already reduced below n
  always_comb begin
    idx_sum = SIZE_W'(idx_r) + SIZE_W'(step_r);
    idx_nxt = (idx_sum >= n_eff) ? IDX_W'(idx_sum - n_eff) : idx_sum[IDX_W-1:0];
  end

  // item, hash and walk registers
  always_ff @(posedge clk) begin
    if (ctrl.item_ld) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      age_r <= in_age;
    end
    if (ctrl.home_ld) begin
      idx_r    <= div_rem[IDX_W-1:0];
      probes_r <= '0;
    end else if (ctrl.probe_adv) begin
      idx_r    <= idx_nxt;
      probes_r <= probes_r + 1'b1;
    end
    if (ctrl.step_p_ld) begin
      step_r <= p_eff - div_rem[PRIME_W-1:0];
    end else if (ctrl.step_n_ld) begin
      step_r <= div_rem[PRIME_W-1:0];
    end
  end

  // average scan accumulators
  always_ff @(posedge clk) begin
    if (ctrl.avg_clr) begin
      scan_r  <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (ctrl.avg_adv) begin
      scan_r <= scan_r + 1'b1;
      if (rd_mark == MARK_USED) begin
        total_r <= total_r + SUM_W'(rd_entry.age);
        count_r <= count_r + 1'b1;
      end
    end
  end

  // slot store; valid bits stand in for the all-empty reset
  assign ram_addr = ctrl.scan_sel ? scan_r[IDX_W-1:0] : idx_r;

  dhte_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ctrl.slot_wr),
    .waddr (idx_r),
    .wdata (wr_entry),
    .raddr (ram_addr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.slot_wr) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[ram_addr];
  end

  assign rd_mark = vld_q_r ? rd_entry.mark : MARK_EMPTY;

  // entry written back on a hit
  always_comb begin
    wr_entry = rd_entry;
    case (cmd_r)
      CMD_INSERT: begin
        wr_entry.mark = MARK_USED;
        wr_entry.key  = key_r;
        wr_entry.age  = age_r;
      end
      CMD_UPDATE: begin
        wr_entry.mark = MARK_USED;
        wr_entry.age  = age_r;
      end
      CMD_DELETE: wr_entry.mark = MARK_TOMB;
      default: ;
    endcase
  end

  // status to controller
  always_comb begin
    stat.cmd        = cmd_r;
    stat.div_done   = div_done;
    stat.walk_end   = probes_r == n_eff;
    stat.slot_hit   = (cmd_r == CMD_INSERT) ? (rd_mark != MARK_USED)
                    : (rd_mark == MARK_USED && rd_entry.key == key_r);
    stat.slot_empty = rd_mark == MARK_EMPTY;
    stat.scan_end   = scan_r == n_eff;
    stat.count_zero = count_r == '0;
    stat.out_free   = !out_valid_r || out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_slot_r   <= '0;
      out_probes_r <= '0;
      out_mean_r   <= '0;
      case (ctrl.res_kind)
        RES_HIT: begin
          out_status_r <= (cmd_r == CMD_SEARCH) ? ST_FOUND : ST_DONE;
          out_slot_r   <= idx_r;
          out_probes_r <= probes_r;
        end
        RES_MISS: begin
          out_status_r <= (cmd_r == CMD_INSERT) ? ST_FULL : ST_MISS;
          out_probes_r <= probes_r;
        end
        RES_NONE: out_status_r <= ST_NONE;
        RES_MEAN: begin
          out_status_r <= ST_DONE;
          out_mean_r   <= div_quo[MEAN_W-1:0];
        end
        default: out_status_r <= ST_MISS;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_probes = out_probes_r;
  assign out_mean   = out_mean_r;

endmodule

// ===== sv/dhte_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhte_ctrl
// Command sequencer: hashing, probe walk, average scan and result hand-off.
// ----------------------------------------------------------------------------
module dhte_ctrl import dhte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_HOME_WAIT, S_PRIME_WAIT, S_STEP_START, S_STEP_WAIT,
    S_PROBE_RD, S_PROBE_CHK, S_AVG_RD, S_AVG_CHK, S_MEAN_WAIT, S_RESP
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t res_kind_r, res_kind_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_kind_nxt  = res_kind_r;
    ctrl          = '0;
    ctrl.div_sel  = DIV_HOME;
    ctrl.res_kind = res_kind_r;
    in_ready      = state_r == S_IDLE;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.item_ld = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_INSERT, CMD_SEARCH, CMD_UPDATE, CMD_DELETE: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = DIV_HOME;
            state_nxt      = S_HOME_WAIT;
          end
          CMD_AVERAGE: begin
            ctrl.avg_clr = 1'b1;
            state_nxt    = S_AVG_RD;
          end
          default: begin
            res_kind_nxt = RES_BAD;
            state_nxt    = S_RESP;
          end
        endcase
      end
      // home slot = key mod n
      S_HOME_WAIT: begin
        if (stat.div_done) begin
          ctrl.home_ld   = 1'b1;
          ctrl.div_start = 1'b1;
          ctrl.div_sel   = DIV_PRIME;
          state_nxt      = S_PRIME_WAIT;
        end
      end
      // step = p - key mod p
      S_PRIME_WAIT: begin
        ctrl.div_sel = DIV_PRIME;
        if (stat.div_done) begin
          ctrl.step_p_ld = 1'b1;
          state_nxt      = S_STEP_START;
        end
      end
      // step register now holds p - key mod p; reduce it mod n
      S_STEP_START: begin
        ctrl.div_start = 1'b1;
        ctrl.div_sel   = DIV_STEP;
        state_nxt      = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        ctrl.div_sel = DIV_STEP;
        if (stat.div_done) begin
          ctrl.step_n_ld = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        if (stat.walk_end) begin
          res_kind_nxt = RES_MISS;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_PROBE_CHK;
        end
      end
      S_PROBE_CHK: begin
        if (stat.slot_hit) begin
          ctrl.slot_wr = stat.cmd != CMD_SEARCH;
          res_kind_nxt = RES_HIT;
          state_nxt    = S_RESP;
        end else if (stat.cmd != CMD_INSERT && stat.slot_empty) begin
          res_kind_nxt = RES_MISS;
          state_nxt    = S_RESP;
        end else begin
          ctrl.probe_adv = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_AVG_RD: begin
        ctrl.scan_sel = 1'b1;
        if (stat.scan_end) begin
          if (stat.count_zero) begin
            res_kind_nxt = RES_NONE;
            state_nxt    = S_RESP;
          end else begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel   = DIV_MEAN;
            state_nxt      = S_MEAN_WAIT;
          end
        end else begin
          state_nxt = S_AVG_CHK;
        end
      end
      S_AVG_CHK: begin
        ctrl.avg_adv = 1'b1;
        state_nxt    = S_AVG_RD;
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) begin
          res_kind_nxt = RES_MEAN;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.out_ld = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_kind_r <= RES_BAD;
    end else begin
      state_r    <= state_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

endmodule

// ===== sv/double_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open-addressing hash table with double hashing over 128 slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  : command items (cmd, record_key, record_age), valid/ready.
//   out_item : one result item per command (status, slot_index, probe_count,
//              mean_age), held in an output register until taken.
//   cfg_wr   : register writes (0 table_size, 1 step_prime), always ready;
//              write only while the engine is idle.
// Flow: one command at a time. A shared bit-serial divider (one bit per
//   cycle) forms key mod n, key mod p and the step mod n before the probe
//   walk, which reads and checks one slot per probe. The average command
//   scans the slots one by one, then runs the divider once on the age sum.
//   Unknown commands are answered without a divider run, with a miss status.
// Stall: a finished result waits in the output register; in_item.ready
//   returns high once the result is loaded, so a new command is taken while
//   the previous result still waits.
// Reset: rst_n (synchronous, active low) marks all slots empty at once
//   through per-slot valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_hash_table_engine import dhte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dhte_in_if.sink       in_item,
  dhte_out_if.source    out_item,
  dhte_cfg_if.sink      cfg_wr
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_item.ready = in_ready;
  assign cfg_wr.ready  = 1'b1;

  dhte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dhte_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_cmd     (in_item.cmd),
    .in_key     (in_item.record_key),
    .in_age     (in_item.record_age),
    .cfg_valid  (cfg_wr.valid),
    .cfg_index  (cfg_wr.reg_index),
    .cfg_data   (cfg_wr.wr_data),
    .out_ready  (out_item.ready),
    .out_valid  (out_item.valid),
    .out_status (out_item.status),
    .out_slot   (out_item.slot_index),
    .out_probes (out_item.probe_count),
    .out_mean   (out_item.mean_age)
  );

endmodule

// ===== sv/dhte_checker.sv =====
// ----------------------------------------------------------------------------
// dhte_checker
// Port-level checks of the hash table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_hash_table_engine_defines.svh"

module dhte_checker import dhte_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [IDX_W-1:0]    slot_index,
  input logic [CNT_W-1:0]    probe_count,
  input logic [MEAN_W-1:0]   mean_age
);

  // a waiting result is not dropped
  `DHTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one command at a time: ready drops after an item is taken
  `DHTE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

  // failures and empty averages carry no slot and no mean
  `DHTE_ASSERT_NOW(a_miss_fields, out_valid && (status == ST_MISS || status == ST_FULL || status == ST_NONE), slot_index == '0 && mean_age == '0, "miss result with slot or mean set")

  // walks are bounded by the capacity and the status is a defined code
  `DHTE_ASSERT_NOW(a_probe_bound, out_valid, probe_count <= CNT_W'(CAPACITY) && status <= ST_NONE, "probe count or status out of range")

endmodule

bind double_hash_table_engine dhte_checker u_dhte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .status      (out_item.status),
  .slot_index  (out_item.slot_index),
  .probe_count (out_item.probe_count),
  .mean_age    (out_item.mean_age)
);
